/* rtl/core/delf_pkg.sv */
// ----------------------------------------------------------------------------
// Deblocking edge line filter package
// Shared types, register map and step-size helpers for the line filter.
// ----------------------------------------------------------------------------
package delf_pkg;

    localparam int PIX_W = 8;
    localparam int QP_W  = 5;

    // Register map, by word index.
    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_SOFT_ENABLE = 1'b0;

    typedef logic [PIX_W-1:0] pix_t;

    // One line of pixels around the edge plus its side information.
    typedef struct packed {
        pix_t            pm3;
        pix_t            pm2;
        pix_t            pm1;
        pix_t            p0;
        pix_t            p1;
        pix_t            p2;
        logic [QP_W-1:0] qp;
        logic            cols;
        logic            strong_here;
        logic            strong_neighbor;
    } line_t;

    // One filtered line.
    typedef struct packed {
        pix_t pm3;
        pix_t pm2;
        pix_t pm1;
        pix_t p0;
        pix_t p1;
        pix_t p2;
        logic was_filtered;
        logic used_hard;
    } result_t;

    // After the first stage: edge decision made, pair differences known.
    typedef struct packed {
        pix_t              pm3;
        pix_t              pm2;
        pix_t              pm1;
        pix_t              p0;
        pix_t              p1;
        pix_t              p2;
        logic signed [8:0] d_next;
        logic signed [8:0] d_outer;
        logic              filt;
        logic              hard;
        logic              cols;
    } stage1_t;

    // After the second stage: signed corrections and the inner average.
    typedef struct packed {
        pix_t              pm3;
        pix_t              pm2;
        pix_t              pm1;
        pix_t              p0;
        pix_t              p1;
        pix_t              p2;
        pix_t              avg;
        logic signed [7:0] delta_next;
        logic signed [7:0] delta_outer;
        logic              filt;
        logic              hard;
    } stage2_t;

    // Magnitude of a 9-bit signed pixel difference.
    function automatic pix_t abs_diff(input logic signed [8:0] d);
        logic [8:0] neg;
        neg = ~d + 9'd1;
        return d[8] ? neg[7:0] : d[7:0];
    endfunction

    // (mag + bias) >> shift, with bias 3/shift 2, 7/3 or 14/3.
    function automatic logic [6:0] round_step(input pix_t mag, input logic [3:0] bias,
                                              input logic by_four);
        logic [8:0] sum;
        sum = {1'b0, mag} + {5'd0, bias};
        return by_four ? sum[8:2] : {1'b0, sum[8:3]};
    endfunction

    // Signed correction applied to the earlier pixel of a pair.
    function automatic logic signed [7:0] signed_step(input logic [6:0] mag,
                                                      input logic neg);
        logic [7:0] m;
        m = {1'b0, mag};
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

/* rtl/core/deblocking_edge_line_filter_core.sv */
// ----------------------------------------------------------------------------
// Deblocking edge line filter core
// Filters one six-pixel line across an 8x8 block edge per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on the s_axis channel carries one line of six
//   pixels (three before and three after the edge), the quantizer and the
//   edge flags. Each output transaction on the m_axis channel carries the
//   filtered line with two status bits. Lines are independent, one result
//   per line, in order.
//   m_axis_tvalid rises once a line has passed all three register stages.
//   The throughput is one line per cycle while the receiver keeps
//   m_axis_tready high; the stages are the edge test, the step-size
//   computation and the pixel update with output register.
//   When the receiver stalls, stages fill up in place and bubbles close, so
//   s_axis_tready only drops once all three stages hold a line.
//   Reset empties the pipeline and sets soft_enable to 1.
//   soft_enable sits at byte address 0 of the APB port and is sampled when a
//   line enters; change it only while no line is in flight.
// ----------------------------------------------------------------------------
module deblocking_edge_line_filter_core
    import delf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Input line
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pixel_m3, pixel_m2, pixel_m1, pixel_0, pixel_p1, pixel_p2 (8 each), qp (5), pad
    input  logic [55:0]       s_axis_tdata,
    // across_columns, strong_here, strong_neighbor
    input  logic [2:0]        s_axis_tuser,
    // Filtered line
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_m3, out_m2, out_m1, out_0, out_p1, out_p2 (8 each)
    output logic [47:0]       m_axis_tdata,
    // was_filtered, used_hard
    output logic [1:0]        m_axis_tuser
);

    logic    soft_enable_reg;
    logic    cfg_write;
    logic    sel_soft;
    line_t   in_item;
    result_t out_item;

    // Register decode: one word, selected by the word index of paddr.
    assign pready    = 1'b1;
    assign sel_soft  = (paddr[ADDR_W-1:2] == REG_SOFT_ENABLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = sel_soft ? {31'd0, soft_enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_enable_reg <= 1'b1;
        end
        else if (cfg_write && sel_soft)
        begin
            soft_enable_reg <= pwdata[0];
        end
    end

    // Unpack the input transaction.
    always_comb
    begin
        in_item.pm3             = s_axis_tdata[7:0];
        in_item.pm2             = s_axis_tdata[15:8];
        in_item.pm1             = s_axis_tdata[23:16];
        in_item.p0              = s_axis_tdata[31:24];
        in_item.p1              = s_axis_tdata[39:32];
        in_item.p2              = s_axis_tdata[47:40];
        in_item.qp              = s_axis_tdata[52:48];
        in_item.cols            = s_axis_tuser[0];
        in_item.strong_here     = s_axis_tuser[1];
        in_item.strong_neighbor = s_axis_tuser[2];
    end

    delf_pipe u_pipe
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .soft_enable (soft_enable_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_item    (out_item)
    );

    // Pack the output transaction.
    assign m_axis_tdata = {out_item.p2, out_item.p1, out_item.p0,
                           out_item.pm1, out_item.pm2, out_item.pm3};
    assign m_axis_tuser = {out_item.used_hard, out_item.was_filtered};

endmodule

/* rtl/core/delf_pipe.sv */
// ----------------------------------------------------------------------------
// Deblocking edge line filter pipeline
// Three-stage datapath: edge test, step sizes, pixel update and output.
// ----------------------------------------------------------------------------
module delf_pipe
    import delf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    soft_enable,
    input  logic    in_valid,
    output logic    in_ready,
    input  line_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    logic    vld1_reg, vld2_reg, vld3_reg;
    logic    en1, en2, en3;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    result_t s3_reg, s3_next;

    // Each stage moves when it is empty or the stage after it moves.
    assign en3      = !vld3_reg || out_ready;
    assign en2      = !vld2_reg || en3;
    assign en1      = !vld1_reg || en2;
    assign in_ready = en1;

    // Stage 1: edge test and pair differences.
    always_comb
    begin
        logic signed [8:0] d_edge;
        pix_t              mag;
        logic              nonzero;
        logic              pass_hard;
        logic              pass_soft;
        logic              hard;
        d_edge    = $signed({1'b0, in_item.p0}) - $signed({1'b0, in_item.pm1});
        mag       = abs_diff(d_edge);
        nonzero   = (d_edge != 9'sd0);
        pass_hard = nonzero && (mag < {2'b00, in_item.qp, 1'b0});
        pass_soft = nonzero && (mag < {3'b000, in_item.qp}) && soft_enable;
        hard      = in_item.strong_here && in_item.strong_neighbor;

        s1_next.pm3     = in_item.pm3;
        s1_next.pm2     = in_item.pm2;
        s1_next.pm1     = in_item.pm1;
        s1_next.p0      = in_item.p0;
        s1_next.p1      = in_item.p1;
        s1_next.p2      = in_item.p2;
        s1_next.d_next  = $signed({1'b0, in_item.p1}) - $signed({1'b0, in_item.pm2});
        s1_next.d_outer = $signed({1'b0, in_item.p2}) - $signed({1'b0, in_item.pm3});
        s1_next.filt    = hard ? pass_hard : pass_soft;
        s1_next.hard    = hard;
        s1_next.cols    = in_item.cols;
    end

    // Stage 2: closing steps and the inner average.
    always_comb
    begin
        logic [8:0] pair_sum;
        logic [3:0] bias_outer;
        logic [6:0] step_next;
        logic [6:0] step_outer;
        pair_sum   = {1'b0, s1_reg.pm1} + {1'b0, s1_reg.p0}
                   + {8'd0, s1_reg.cols && !s1_reg.hard};
        // Column edges with a falling outer pair take the stronger step.
        bias_outer = (s1_reg.cols && s1_reg.d_outer[8]) ? 4'd14 : 4'd7;
        step_next  = round_step(abs_diff(s1_reg.d_next), 4'd3, 1'b0);
        if (s1_reg.hard)
        begin
            step_next = round_step(abs_diff(s1_reg.d_next), 4'd3, 1'b1);
        end
        else
        begin
            step_next = round_step(abs_diff(s1_reg.d_next), 4'd7, 1'b0);
        end
        step_outer = round_step(abs_diff(s1_reg.d_outer), bias_outer, 1'b0);

        s2_next.pm3         = s1_reg.pm3;
        s2_next.pm2         = s1_reg.pm2;
        s2_next.pm1         = s1_reg.pm1;
        s2_next.p0          = s1_reg.p0;
        s2_next.p1          = s1_reg.p1;
        s2_next.p2          = s1_reg.p2;
        s2_next.avg         = pair_sum[8:1];
        s2_next.delta_next  = signed_step(step_next, s1_reg.d_next[8]);
        s2_next.delta_outer = signed_step(step_outer, s1_reg.d_outer[8]);
        s2_next.filt        = s1_reg.filt;
        s2_next.hard        = s1_reg.hard;
    end

    // Stage 3: apply the corrections.
    always_comb
    begin
        logic [8:0] dn;
        logic [8:0] dout;
        logic [8:0] pm2_sum, p1_sum, pm3_sum, p2_sum;
        dn      = {s2_reg.delta_next[7], s2_reg.delta_next};
        dout    = {s2_reg.delta_outer[7], s2_reg.delta_outer};
        pm2_sum = {1'b0, s2_reg.pm2} + dn;
        p1_sum  = {1'b0, s2_reg.p1} - dn;
        pm3_sum = {1'b0, s2_reg.pm3} + dout;
        p2_sum  = {1'b0, s2_reg.p2} - dout;

        s3_next.pm3          = s2_reg.pm3;
        s3_next.pm2          = s2_reg.pm2;
        s3_next.pm1          = s2_reg.pm1;
        s3_next.p0           = s2_reg.p0;
        s3_next.p1           = s2_reg.p1;
        s3_next.p2           = s2_reg.p2;
        s3_next.was_filtered = s2_reg.filt;
        s3_next.used_hard    = s2_reg.hard;
        if (s2_reg.filt)
        begin
            s3_next.pm2 = pm2_sum[7:0];
            s3_next.pm1 = s2_reg.avg;
            s3_next.p0  = s2_reg.avg;
            s3_next.p1  = p1_sum[7:0];
            if (s2_reg.hard)
            begin
                s3_next.pm3 = pm3_sum[7:0];
                s3_next.p2  = p2_sum[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                vld1_reg <= in_valid;
            end
            if (en2)
            begin
                vld2_reg <= vld1_reg;
            end
            if (en3)
            begin
                vld3_reg <= vld2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = vld3_reg;
    assign out_item  = s3_reg;

    // A full, stalled pipeline is the only reason to refuse input.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (vld1_reg && vld2_reg && vld3_reg && !out_ready))
        else $error("input refused while the pipeline has room");

    // A held middle stage keeps its contents.
    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld2_reg && !en2) |=> (vld2_reg && $stable(s2_reg)))
        else $error("stage 2 changed while stalled");

    // Any filtered line leaves the inner pair equal.
    a_inner_pair_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (vld3_reg && s3_reg.was_filtered) |-> (s3_reg.pm1 == s3_reg.p0))
        else $error("filtered inner pair differs");

    // Soft filtering is never reported while it is switched off at entry.
    a_soft_off: assert property (@(posedge clk) disable iff (!rst_n)
        (en1 && in_valid && !soft_enable && !(in_item.strong_here && in_item.strong_neighbor))
        |=> !s1_reg.filt)
        else $error("soft filter applied while disabled");

endmodule
